// File: src/blcd_pkg.sv
// Shared types and constants for the button lockout debounce counter.
package blcd_pkg;

   // Widths of the request and response fields
   localparam int unsigned TIME_W     = 64;
   localparam int unsigned PINS_W     = 16;
   localparam int unsigned ID_W       = 4;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned FREEZE_W   = 20;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 48;

   // Request modes (the remaining code is ignored)
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   // Register map: index taken from paddr[2]
   localparam logic REG_FREEZE = 1'b0;

   localparam logic [FREEZE_W-1:0] FREEZE_RESET_US = 20'd20000;

   // Per-request control broadcast to every lane
   typedef struct packed {
      logic                sample;
      logic                clear_all;
      logic [TIME_W-1:0]   now_us;
      logic [FREEZE_W-1:0] freeze_us;
   } lane_ctl_type;

   // Response payload, pressed mask in the lowest bits
   typedef struct packed {
      logic [COUNT_W-1:0] press_count;
      logic [PINS_W-1:0]  pressed_mask;
   } rsp_type;

endpackage

// File: src/blcd_lane.sv
// One button lane: debounced level, lockout deadline and press counter.
module blcd_lane (
   input  logic                 clock,
   input  logic                 reset,
   input  blcd_pkg::lane_ctl_type ctl,
   input  logic                 raw_pressed,
   input  logic                 clear_one,
   output logic                 level_next,
   output logic [31:0]          counter
);
   import blcd_pkg::*;

   logic               level_ff, level_in;
   logic [TIME_W-1:0]  deadline_ff, deadline_in;
   logic [COUNT_W-1:0] counter_ff, counter_in;

   // Work out the lane's next state for this request
   always_comb begin
      level_in    = level_ff;
      deadline_in = deadline_ff;
      counter_in  = counter_ff;
      if (ctl.sample) begin
         if ((ctl.now_us >= deadline_ff) && (raw_pressed != level_ff)) begin
            level_in    = raw_pressed;
            deadline_in = ctl.now_us + TIME_W'(ctl.freeze_us);
            if (raw_pressed) begin
               counter_in = counter_ff + COUNT_W'(1);
            end
         end
      end else if (ctl.clear_all || clear_one) begin
         counter_in = '0;
      end
   end

   // Hold the lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= 1'b0;
         deadline_ff <= '0;
         counter_ff  <= '0;
      end else begin
         level_ff    <= level_in;
         deadline_ff <= deadline_in;
         counter_ff  <= counter_in;
      end
   end

   assign level_next = level_in;
   assign counter    = counter_ff;

   // A new press always adds exactly one to the counter
   a_press_counts: assert property (@(posedge clock) disable iff (reset)
      $rose(level_ff) |-> counter_ff == $past(counter_ff) + COUNT_W'(1))
      else $error("press not counted once");

   // The level moves only on a sample request or a reset
   a_level_on_sample: assert property (@(posedge clock)
      !$stable(level_ff) |-> ($past(ctl.sample) || $past(reset)))
      else $error("level changed without a sample");

endmodule

// File: src/blcd_merge.sv
// Merging stage: builds the mask and selected count, two-entry output stage.
module blcd_merge #(
   parameter int unsigned BUTTONS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         capture,
   input  logic                         query,
   input  logic [3:0]                   button_id,
   input  logic [BUTTONS-1:0]           levels_next,
   input  logic [BUTTONS-1:0][31:0]     counters,
   output logic                         req_ready,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [47:0]                  rsp_tdata
);
   import blcd_pkg::*;

   rsp_type            result;
   logic [COUNT_W-1:0] sel_count;
   rsp_type            out_ff, out_in, skid_ff, skid_in;
   logic               out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic               take;

   // Pick the queried counter; an id beyond the bank selects nothing
   always_comb begin
      sel_count = '0;
      for (int i = 0; i < BUTTONS; i++) begin
         if (query && (button_id == ID_W'(i))) begin
            sel_count = counters[i];
         end
      end
   end

   assign result.press_count  = sel_count;
   assign result.pressed_mask = PINS_W'(levels_next);

   assign take      = out_valid_ff && rsp_tready;
   assign req_ready = !skid_valid_ff;

   // Advance the output register and the skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (capture) begin
         if (!out_valid_ff || take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   // The skid entry is only ever filled behind a waiting response
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   // A parked response is not dropped while the sink stalls
   a_skid_held: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("skid entry lost under stall");

   // A request is never captured while both entries are full
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && skid_valid_ff) |-> !capture)
      else $error("request captured into a full output stage");

endmodule

// File: src/button_lockout_debounce_counter_unit.sv
// Synchronous reset clears levels, deadlines, counters and the output stage,
// and sets the lockout to 20000 us. Each response is registered. Throughput:
// one request per cycle while the skid entry is empty; every button lane does
// its deadline compare and deadline add side by side, and a two-entry output
// stage keeps taking requests while one response waits.
module button_lockout_debounce_counter_unit #(
   parameter int unsigned BUTTONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // now_us[63:0], raw_levels[79:64], button_id[83:80]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pressed_mask[15:0], press_count[47:16]
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import blcd_pkg::*;

   logic [FREEZE_W-1:0]         freeze_ff, freeze_in;
   logic                        accept;
   logic [TIME_W-1:0]           now_us;
   logic [PINS_W-1:0]           raw_levels;
   logic [ID_W-1:0]             button_id;
   logic [MODE_W-1:0]           mode;
   lane_ctl_type                ctl;
   logic [BUTTONS-1:0]          levels_next;
   logic [BUTTONS-1:0][31:0]    counters;
   logic                        query;

   // Configuration register
   assign csr_pready = 1'b1;
   always_comb begin
      freeze_in = freeze_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_paddr[2] == REG_FREEZE)) begin
         freeze_in = csr_pwdata[FREEZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freeze_ff <= FREEZE_RESET_US;
      end else begin
         freeze_ff <= freeze_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_FREEZE) ? 32'(freeze_ff) : 32'd0;

   // Unpack the request
   assign now_us     = req_tdata[63:0];
   assign raw_levels = req_tdata[79:64];
   assign button_id  = req_tdata[83:80];
   assign mode       = req_tuser;
   assign accept     = req_tvalid && req_tready;

   // Decode the mode into lane controls
   always_comb begin
      ctl.sample    = 1'b0;
      ctl.clear_all = 1'b0;
      ctl.now_us    = now_us;
      ctl.freeze_us = freeze_ff;
      query         = 1'b0;
      case (mode)
         MODE_SAMPLE: ctl.sample    = accept;
         MODE_QUERY:  query         = accept;
         MODE_CLEAR:  ctl.clear_all = accept;
         default:     ;
      endcase
   end

   // One lane per button
   for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
      blcd_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .raw_pressed (!raw_levels[g]),
         .clear_one   (query && (button_id == ID_W'(g))),
         .level_next  (levels_next[g]),
         .counter     (counters[g])
      );
   end

   blcd_merge #(
      .BUTTONS (BUTTONS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .capture     (accept),
      .query       (query),
      .button_id   (button_id),
      .levels_next (levels_next),
      .counters    (counters),
      .req_ready   (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
